FILE: rtl/key_hash_core_placement_macros.svh
// assertion macros for the key hash core placement block
// used by the top level; expects clk and rst_n in scope
`ifndef KEY_HASH_CORE_PLACEMENT_MACROS_SVH
`define KEY_HASH_CORE_PLACEMENT_MACROS_SVH

// same-cycle implication, checked out of reset
`define KHCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("khcp check failed");

// next-cycle implication, checked out of reset
`define KHCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("khcp check failed");

`endif

FILE: rtl/khcp_pkg.sv
// shared types and constants for the key hash core placement block
// used by khcp_ctrl, khcp_dp and key_hash_core_placement
package khcp_pkg;

  localparam int KeyW     = 8;
  localparam int HashW    = 32;
  localparam int CoordW   = 8;
  localparam int SizeW    = 9;
  localparam int CoreW    = 5;
  localparam int ModeW    = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 9;
  localparam int DivCntW  = 3;

  localparam logic [DivCntW-1:0] DIV_LAST = 3'd7;

  typedef enum logic [ModeW-1:0] {
    MODE_DJB2  = 2'd0,
    MODE_SHXOR = 2'd1,
    MODE_OAAT  = 2'd2,
    MODE_ROBIN = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE  = 3'd0,
    CFG_COLS  = 3'd1,
    CFG_ROWS  = 3'd2,
    CFG_FIRST = 3'd3,
    CFG_COUNT = 3'd4
  } cfg_reg_t;

  localparam logic [HashW-1:0] SEED_DJB2  = 32'd5381;
  localparam logic [HashW-1:0] SEED_SHXOR = 32'h5555_5555;
  localparam logic [HashW-1:0] SEED_ZERO  = 32'h0000_0000;

  localparam logic [SizeW-1:0] RST_COLS  = 9'd2;
  localparam logic [SizeW-1:0] RST_ROWS  = 9'd2;
  localparam logic [CoreW-1:0] RST_FIRST = 5'd2;
  localparam logic [CoreW-1:0] RST_COUNT = 5'd16;

  // controller to datapath
  typedef struct packed {
    logic byte_step;
    logic capture;
    logic robin_step;
    logic mix1;
    logic mix2;
    logic mix3;
    logic div_init;
    logic div_step;
    logic out_load;
  } khcp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_robin;
    logic is_oaat;
    logic div_last;
    logic out_free;
  } khcp_stat_t;

  function automatic logic [HashW-1:0] seed_of(mode_t m);
    logic [HashW-1:0] s;
    case (m)
      MODE_DJB2:  s = SEED_DJB2;
      MODE_SHXOR: s = SEED_SHXOR;
      default:    s = SEED_ZERO;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/khcp_ctrl.sv
// sequencer for the key hash core placement block
// depends on khcp_pkg; drives khcp_dp through khcp_cmd_t
module khcp_ctrl import khcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last_byte,
  input  logic       in_is_put,
  output logic       in_stall,
  input  khcp_stat_t stat,
  output khcp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MIX1 = 6'b000010,
    S_MIX2 = 6'b000100,
    S_MIX3 = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.is_robin) begin
            // pulls and inner bytes leave the odometer alone
            if (in_last_byte && in_is_put) begin
              cmd.robin_step = 1'b1;
              state_nxt      = S_OUT;
            end
          end else begin
            cmd.byte_step = 1'b1;
            if (in_last_byte) begin
              cmd.capture = 1'b1;
              if (stat.is_oaat) begin
                state_nxt = S_MIX1;
              end else begin
                cmd.div_init = 1'b1;
                state_nxt    = S_DIV;
              end
            end
          end
        end
      end
      S_MIX1: begin
        cmd.mix1  = 1'b1;
        state_nxt = S_MIX2;
      end
      S_MIX2: begin
        cmd.mix2  = 1'b1;
        state_nxt = S_MIX3;
      end
      S_MIX3: begin
        cmd.mix3     = 1'b1;
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/khcp_dp.sv
// datapath for the key hash core placement block: config, hash, remainder unit,
// round-robin odometer and output register; depends on khcp_pkg
module khcp_dp import khcp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [KeyW-1:0]     in_key_byte,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  khcp_cmd_t           cmd,
  output khcp_stat_t          stat,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [CoordW-1:0]   out_dest_x,
  output logic [CoordW-1:0]   out_dest_y,
  output logic [CoreW-1:0]    out_dest_core,
  output logic [HashW-1:0]    out_key_hash
);

  mode_t            mode_r;
  logic [SizeW-1:0] cols_r, rows_r;
  logic [CoreW-1:0] first_r, count_r;

  logic [HashW-1:0] acc_r, acc_nxt;
  logic [HashW-1:0] fin_r, fin_nxt;
  logic [HashW-1:0] step_hash;

  logic [CoordW-1:0] robin_x_r, robin_x_nxt;
  logic [CoordW-1:0] robin_y_r, robin_y_nxt;
  logic [CoreW-1:0]  robin_core_r, robin_core_nxt;

  logic [CoordW-1:0]  rem_x_r, rem_x_nxt;
  logic [CoordW-1:0]  rem_y_r, rem_y_nxt;
  logic [CoreW-1:0]   rem_c_r, rem_c_nxt;
  logic [DivCntW-1:0] div_cnt_r, div_cnt_nxt;

  logic              out_valid_r;
  logic [CoordW-1:0] out_x_r, out_y_r;
  logic [CoreW-1:0]  out_core_r;
  logic [HashW-1:0]  out_hash_r;

  logic [SizeW-1:0]   cols_eff, rows_eff;
  logic [CoreW-1:0]   count_eff;
  logic [DivCntW-1:0] bit_sel;
  logic [CoordW-1:0]  slice_x, slice_y, slice_c;
  logic [SizeW-1:0]   x_trial, y_trial;
  logic [CoreW:0]     c_trial;

  logic [CoreW:0]   robin_top;
  logic [CoreW-1:0] robin_nc;
  logic [SizeW-1:0] robin_nx, robin_ny;

  function automatic logic [HashW-1:0] hash_step(mode_t m, logic [HashW-1:0] h,
                                                 logic [KeyW-1:0] b);
    logic [HashW-1:0] t;
    logic [HashW-1:0] bx;
    bx = {{(HashW-KeyW){1'b0}}, b};
    case (m)
      MODE_DJB2:  t = (h << 5) + h + bx;
      MODE_SHXOR: t = (h ^ bx) << 5;
      MODE_OAAT: begin
        t = h + bx;
        t = t + (t << 10);
        t = t ^ (t >> 6);
      end
      default:    t = '0;
    endcase
    return t;
  endfunction

  // a size of zero behaves as one
  assign cols_eff  = (cols_r  == '0) ? SizeW'(1) : cols_r;
  assign rows_eff  = (rows_r  == '0) ? SizeW'(1) : rows_r;
  assign count_eff = (count_r == '0) ? CoreW'(1) : count_r;

  assign step_hash = hash_step(mode_r, acc_r, in_key_byte);

  // hash accumulator and final hash
  always_comb begin
    acc_nxt = acc_r;
    fin_nxt = fin_r;
    if (cmd.byte_step) begin
      acc_nxt = step_hash;
    end
    if (cmd.capture) begin
      fin_nxt = step_hash;
      acc_nxt = seed_of(mode_r);
    end
    if (cmd.mix1) begin
      fin_nxt = fin_r + (fin_r << 3);
    end
    if (cmd.mix2) begin
      fin_nxt = fin_r ^ (fin_r >> 11);
    end
    if (cmd.mix3) begin
      fin_nxt = fin_r + (fin_r << 15);
    end
    // a mode write drops any partial key
    if (cfg_wr_en && cfg_index == CFG_MODE) begin
      acc_nxt = seed_of(mode_t'(cfg_data[ModeW-1:0]));
    end
  end

  // bit-serial remainder, msb first, three lanes in step
  assign bit_sel = ~div_cnt_r;
  assign slice_x = fin_r[23:16];
  assign slice_y = fin_r[15:8];
  assign slice_c = fin_r[7:0];
  assign x_trial = {rem_x_r, slice_x[bit_sel]};
  assign y_trial = {rem_y_r, slice_y[bit_sel]};
  assign c_trial = {rem_c_r, slice_c[bit_sel]};

  always_comb begin
    rem_x_nxt   = rem_x_r;
    rem_y_nxt   = rem_y_r;
    rem_c_nxt   = rem_c_r;
    div_cnt_nxt = div_cnt_r;
    if (cmd.div_init) begin
      rem_x_nxt   = '0;
      rem_y_nxt   = '0;
      rem_c_nxt   = '0;
      div_cnt_nxt = '0;
    end else if (cmd.div_step) begin
      rem_x_nxt   = (x_trial >= cols_eff) ? CoordW'(x_trial - cols_eff) : x_trial[CoordW-1:0];
      rem_y_nxt   = (y_trial >= rows_eff) ? CoordW'(y_trial - rows_eff) : y_trial[CoordW-1:0];
      rem_c_nxt   = (c_trial >= {1'b0, count_eff}) ?
                    CoreW'(c_trial - {1'b0, count_eff}) : c_trial[CoreW-1:0];
      div_cnt_nxt = div_cnt_r + DivCntW'(1);
    end
  end

  // round-robin odometer: core, then x, then y
  assign robin_top = {1'b0, first_r} + {1'b0, count_eff} - (CoreW+1)'(1);
  assign robin_nc  = robin_core_r + CoreW'(1);
  assign robin_nx  = {1'b0, robin_x_r} + SizeW'(1);
  assign robin_ny  = {1'b0, robin_y_r} + SizeW'(1);

  always_comb begin
    robin_x_nxt    = robin_x_r;
    robin_y_nxt    = robin_y_r;
    robin_core_nxt = robin_core_r;
    if (cmd.robin_step) begin
      robin_core_nxt = robin_nc;
      if ({1'b0, robin_nc} > robin_top) begin
        robin_core_nxt = first_r;
        if (robin_nx >= cols_eff || robin_nx[SizeW-1]) begin
          robin_x_nxt = '0;
          if (robin_ny >= rows_eff || robin_ny[SizeW-1]) begin
            robin_y_nxt = '0;
          end else begin
            robin_y_nxt = robin_ny[CoordW-1:0];
          end
        end else begin
          robin_x_nxt = robin_nx[CoordW-1:0];
        end
      end
    end
    // a first-core write restarts the core walk
    if (cfg_wr_en && cfg_index == CFG_FIRST) begin
      robin_core_nxt = cfg_data[CoreW-1:0] - CoreW'(1);
    end
  end

  // config registers and state that config writes touch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_DJB2;
      cols_r       <= RST_COLS;
      rows_r       <= RST_ROWS;
      first_r      <= RST_FIRST;
      count_r      <= RST_COUNT;
      acc_r        <= seed_of(MODE_DJB2);
      robin_x_r    <= '0;
      robin_y_r    <= '0;
      robin_core_r <= RST_FIRST - CoreW'(1);
    end else begin
      acc_r        <= acc_nxt;
      robin_x_r    <= robin_x_nxt;
      robin_y_r    <= robin_y_nxt;
      robin_core_r <= robin_core_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_MODE:  mode_r  <= mode_t'(cfg_data[ModeW-1:0]);
          CFG_COLS:  cols_r  <= cfg_data[SizeW-1:0];
          CFG_ROWS:  rows_r  <= cfg_data[SizeW-1:0];
          CFG_FIRST: first_r <= cfg_data[CoreW-1:0];
          CFG_COUNT: count_r <= cfg_data[CoreW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    fin_r     <= fin_nxt;
    rem_x_r   <= rem_x_nxt;
    rem_y_r   <= rem_y_nxt;
    rem_c_r   <= rem_c_nxt;
    div_cnt_r <= div_cnt_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (mode_r == MODE_ROBIN) begin
        out_x_r    <= robin_x_r;
        out_y_r    <= robin_y_r;
        out_core_r <= robin_core_r;
        out_hash_r <= '0;
      end else begin
        out_x_r    <= rem_x_r;
        out_y_r    <= rem_y_r;
        out_core_r <= rem_c_r + first_r;
        out_hash_r <= fin_r;
      end
    end
  end

  assign stat.is_robin = (mode_r == MODE_ROBIN);
  assign stat.is_oaat  = (mode_r == MODE_OAAT);
  assign stat.div_last = (div_cnt_r == DIV_LAST);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_dest_x    = out_x_r;
  assign out_dest_y    = out_y_r;
  assign out_dest_core = out_core_r;
  assign out_key_hash  = out_hash_r;

endmodule

FILE: rtl/key_hash_core_placement.sv
// Key hash core placement: takes request key bytes one beat at a time and picks
// the chip x, chip y and core that store the key, from a djb2, shift-xor or
// Jenkins one-at-a-time hash, or from a round-robin odometer on puts. A key byte
// that is not the last one is taken while the sequencer is idle. A last byte in
// djb2 or shift-xor mode is hashed, then goes through the bit-serial remainder
// unit that reduces x, y and core together, then is loaded into the output
// register before the next beat is taken; Jenkins mode adds three mix steps for
// its final mix, and a round-robin put steps the odometer and then loads. The
// load waits, and the input stays stalled, for as long as the previous result is
// still held in the output register. The output register lets key bytes of the
// next request flow in while a result waits to be taken.
// Depends on khcp_pkg, khcp_ctrl, khcp_dp and key_hash_core_placement_macros.svh.
`include "key_hash_core_placement_macros.svh"

module key_hash_core_placement import khcp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KeyW-1:0]     in_key_byte,
  input  logic                in_last_byte,
  input  logic                in_is_put,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CoordW-1:0]   out_dest_x,
  output logic [CoordW-1:0]   out_dest_y,
  output logic [CoreW-1:0]    out_dest_core,
  output logic [HashW-1:0]    out_key_hash,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  khcp_cmd_t  cmd;
  khcp_stat_t stat;
  logic [6:0] work_ops;

  khcp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_is_put    (in_is_put),
    .in_stall     (in_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  khcp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_key_byte   (in_key_byte),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_dest_x    (out_dest_x),
    .out_dest_y    (out_dest_y),
    .out_dest_core (out_dest_core),
    .out_key_hash  (out_key_hash)
  );

  assign work_ops = {cmd.byte_step, cmd.robin_step, cmd.mix1, cmd.mix2, cmd.mix3,
                     cmd.div_step, cmd.out_load};

  // a result is never loaded over one that is still waiting
  `KHCP_ASSERT_IMP(a_load_free, cmd.out_load, (!out_valid || !out_stall))
  // a result shows the cycle after it is loaded
  `KHCP_ASSERT_NXT(a_load_shows, cmd.out_load, out_valid)
  // a result appears only from a load
  `KHCP_ASSERT_IMP(a_rise_from_load, $rose(out_valid), $past(cmd.out_load))
  // the datapath does at most one kind of work per cycle
  `KHCP_ASSERT_IMP(a_one_op, 1'b1, $onehot0(work_ops))

endmodule
